// File: design/fqps_pkg.sv
// ----------------------------------------------------------------------------
// fqps_pkg: shared types for the FIFO queue with peek and search
// Request kinds, status codes, controller states and the command/status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fqps_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_PEEK   = 2'd2,
      KIND_SEARCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY_BAD = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SCAN,
      S_FINISH
   } state_type;

   // peek position that selects the tail entry
   localparam logic [6:0] POS_TAIL = 7'h7F;

   typedef struct packed {
      logic latch;      // capture the request beat
      logic rd_req;     // read one entry for remove or peek
      logic scan_step;  // advance the search walk
      logic finish;     // commit state and load the result register
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     peek_bad;
      logic     scan_done;
   } stat_type;

endpackage

// File: design/fqps_if.sv
// ----------------------------------------------------------------------------
// fqps channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface fqps_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic signed [31:0] item_value;
   logic signed [6:0] position;

   modport source (output valid, kind, item_value, position, input ready);
   modport sink   (input valid, kind, item_value, position, output ready);
endinterface

interface fqps_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic signed [31:0] read_value;
   logic [6:0]        count_or_index;

   modport source (output valid, status, read_value, count_or_index, input ready);
   modport sink   (input valid, status, read_value, count_or_index, output ready);
endinterface

// File: design/fqps_ctrl.sv
// ----------------------------------------------------------------------------
// fqps_ctrl: request sequencer
// Steps one request at a time through decode, entry read or search walk,
// and result load; owns the request ready and result valid flags.
// ----------------------------------------------------------------------------
module fqps_ctrl
   import fqps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_INSERT: state_in = S_FINISH;
               KIND_REMOVE: state_in = stat.empty ? S_FINISH : S_READ;
               KIND_PEEK:   state_in = stat.peek_bad ? S_FINISH : S_READ;
               KIND_SEARCH: state_in = stat.empty ? S_FINISH : S_SCAN;
               default:     state_in = S_FINISH;
            endcase
         end
         S_READ: begin
            cmd.rd_req = 1'b1;
            state_in   = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register can take the beat
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   end

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request taken while a request is in flight");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished request produced no result beat");

endmodule

// File: design/fqps_dp.sv
// ----------------------------------------------------------------------------
// fqps_dp: queue datapath
// Ring buffer memory, head pointer and count, request registers, the
// pipelined search walk and the result register.
// ----------------------------------------------------------------------------
module fqps_dp
   import fqps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        req_kind,
   input  logic signed [31:0] req_item_value,
   input  logic signed [6:0] req_position,
   output logic [1:0]        rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]        rsp_count_or_index
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [PW:0]   DEPTH_P = (PW + 1)'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

   logic signed [31:0] mem [QUEUE_DEPTH];

   logic [PW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   kind_type           kind_ff;
   logic signed [31:0] value_ff;
   logic signed [6:0]  pos_ff;
   logic signed [31:0] rdata_ff;
   logic [CW-1:0]      idx_ff;
   logic               cmp_valid_ff;
   logic [CW-1:0]      cmp_idx_ff;
   logic               found_ff;
   logic [CW-1:0]      found_idx_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] rd_out_ff;
   logic [6:0]         ci_out_ff;

   logic               empty, full, peek_bad, pos_neg;
   logic [XW-1:0]      pos_x, count_x;
   logic [PW-1:0]      rd_off, rd_slot, wr_slot;
   logic [PW:0]        rd_sum, wr_sum;
   logic               issue, rd_en, wr_en, hit, miss;
   status_type         status_in;
   logic signed [31:0] rd_out_in;
   logic [XW-1:0]      ci_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff >= DEPTH_C);
   assign pos_neg = pos_ff[6];
   assign pos_x   = XW'(pos_ff[5:0]);
   assign count_x = XW'(count_ff);
   assign peek_bad = empty || (pos_neg && (pos_ff != POS_TAIL))
                     || (!pos_neg && (pos_x >= count_x));

   always_comb begin
      unique case (kind_ff)
         KIND_REMOVE: rd_off = '0;
         KIND_PEEK:   rd_off = pos_neg ? PW'(count_ff - CW'(1)) : PW'(pos_x);
         KIND_SEARCH: rd_off = PW'(idx_ff);
         default:     rd_off = '0;
      endcase
   end

   // ring index: the sum stays below twice the depth
   assign rd_sum  = {1'b0, head_ff} + {1'b0, rd_off};
   assign rd_slot = (rd_sum >= DEPTH_P) ? PW'(rd_sum - DEPTH_P) : PW'(rd_sum);
   assign wr_sum  = {1'b0, head_ff} + {1'b0, PW'(count_ff)};
   assign wr_slot = (wr_sum >= DEPTH_P) ? PW'(wr_sum - DEPTH_P) : PW'(wr_sum);

   // search walk: issue a read per cycle, compare the beat that came back
   assign issue = (idx_ff < count_ff);
   assign rd_en = cmd.rd_req || (cmd.scan_step && issue);
   assign hit   = cmp_valid_ff && (rdata_ff == value_ff);
   assign miss  = cmp_valid_ff && !hit && (cmp_idx_ff == count_ff - CW'(1));
   assign wr_en = cmd.finish && (kind_ff == KIND_INSERT) && !full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= value_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_slot];
      end
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      rd_out_in = '0;
      ci_in     = count_x;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               ci_in    = XW'(count_in);
            end
         end
         KIND_REMOVE: begin
            if (empty) begin
               status_in = STAT_EMPTY_BAD;
            end else begin
               rd_out_in = rdata_ff;
               head_in   = (head_ff == LAST_P) ? '0 : head_ff + PW'(1);
               count_in  = count_ff - CW'(1);
               ci_in     = XW'(count_in);
            end
         end
         KIND_PEEK: begin
            if (peek_bad) begin
               status_in = STAT_EMPTY_BAD;
            end else begin
               rd_out_in = rdata_ff;
            end
         end
         KIND_SEARCH: begin
            if (empty) begin
               status_in = STAT_EMPTY_BAD;
            end else if (found_ff) begin
               ci_in = XW'(found_idx_ff);
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: status_in = STAT_EMPTY_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (cmd.latch) begin
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= kind_type'(req_kind);
         value_ff <= req_item_value;
         pos_ff   <= req_position;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         cmp_idx_ff <= idx_ff;
         if (hit || miss) begin
            found_ff     <= hit;
            found_idx_ff <= cmp_idx_ff;
         end
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         rd_out_ff <= rd_out_in;
         ci_out_ff <= ci_in[6:0];
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.full      = full;
   assign stat.empty     = empty;
   assign stat.peek_bad  = peek_bad;
   assign stat.scan_done = hit || miss;

   assign rsp_status         = status_ff;
   assign rsp_read_value     = rd_out_ff;
   assign rsp_count_or_index = ci_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < DEPTH_P)
      else $error("head pointer outside ring");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not advance the count");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (cmp_idx_ff < count_ff))
      else $error("search compared an entry past the tail");

endmodule

// File: design/fifo_queue_with_peek_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_peek_search: bounded FIFO with indexed peek and search
// Ring buffer of QUEUE_DEPTH signed 32-bit entries behind valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per beat: kind (insert, remove, peek, search),
//   item_value and position. rsp_ch returns exactly one result beat per
//   request: status, read_value and count_or_index.
//   Requests are handled one at a time. After decode, insert and any request
//   that fails on an empty queue or a bad position go straight to the result
//   load; remove and peek first do one registered memory read; search first
//   walks the queue, reading one stored entry per cycle through the single
//   memory read port, and stops at the first match or after the last entry.
//   The result sits in an output register, so the next request is accepted as
//   soon as the previous one is finished, even while its beat waits. A stalled
//   receiver holds the beat; a finished request then waits before loading.
//   Reset (synchronous, active high) empties the queue at once; the entry
//   memory is not cleared, and only written entries are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_peek_search
   import fqps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   fqps_req_if.sink    req_ch,
   fqps_rsp_if.source  rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   fqps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fqps_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_ch.kind),
      .req_item_value     (req_ch.item_value),
      .req_position       (req_ch.position),
      .rsp_status         (rsp_ch.status),
      .rsp_read_value     (rsp_ch.read_value),
      .rsp_count_or_index (rsp_ch.count_or_index)
   );

endmodule
